/* hdl/sor_pkg.sv */
// Shared constants, register codes and control types for the spiral-order matrix reader.
`default_nettype none
package sor_pkg;

  // Default sizing of the top level
  localparam int MAX_DIM_DEF    = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int ELEM_W    = 32;
  localparam int INDEX_W   = 5;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

  // Input item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  // Spiral side codes
  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // write input value at load pointer
    logic issue;    // read memory at cursor, latch position
    logic deliver;  // fill output register, advance cursor
    logic step;     // move cursor to start of next side
  } sor_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_pending;  // latched item is final element of spiral
    logic pos_ok;        // cursor points at a walked position
  } sor_sts_t;

endpackage
`default_nettype wire

/* hdl/sor_stream_if.sv */
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none
interface sor_in_if;
  import sor_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [ELEM_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface sor_out_if;
  import sor_pkg::*;

  logic               valid;
  logic               ready;
  logic [ELEM_W-1:0]  element;
  logic [INDEX_W-1:0] row_index;
  logic [INDEX_W-1:0] col_index;
  logic               last;

  modport source (output valid, output element, output row_index, output col_index,
                  output last, input ready);
  modport sink   (input valid, input element, input row_index, input col_index,
                  input last, output ready);
endinterface
`default_nettype wire

/* hdl/spiral_order_matrix_reader.sv */
// Top level of the spiral-order matrix reader: controller plus datapath.
//
// Holds a matrix of up to MAX_DIM x MAX_DIM values in an on-chip memory.
// A transfer with mode 0 stores its value at the next row-major slot and
// gives no result; storing slot zero restarts the spiral. A transfer with
// mode 1 returns the next element in clockwise spiral order (top edge, right
// edge, bottom edge, left edge, ring by ring) with its row, column and a
// last flag; after the last element the spiral starts again. num_rows and
// num_cols are written through the cfg_ port; 0 reads as 1 and values above
// MAX_DIM read as MAX_DIM, and any write resets the load pointer and the
// spiral. A spiral transfer reads the memory at the cursor address and
// latches the position, fills the output register, then checks the cursor;
// when its element ends a side, the cursor then steps to the next side
// in the controller's stepping state; for the last element of the spiral
// the cursor simply restarts instead. A side of zero length only ever
// follows the last element, so no further skips occur.
// The result waits in an output register until taken; a spiral
// transfer whose result is ready while the previous one is still untaken
// holds until the output register frees. Values keep their low DATA_WIDTH
// bits (at most 32) and come back sign-extended. Reading a slot never
// loaded returns an undefined value.
`default_nettype none
module spiral_order_matrix_reader #(
  parameter int MAX_DIM    = sor_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = sor_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sor_in_if.sink                             in_chan,
  sor_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [sor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sor_pkg::CFG_W-1:0]     cfg_data
);
  import sor_pkg::*;

  sor_cmd_t cmd;
  sor_sts_t sts;

  sor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sor_datapath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value      (in_chan.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_element   (out_chan.element),
    .out_row_index (out_chan.row_index),
    .out_col_index (out_chan.col_index),
    .out_last      (out_chan.last)
  );

endmodule
`default_nettype wire

/* hdl/sor_ctrl.sv */
// Control state machine: sequences load, read, deliver and cursor stepping.
`default_nettype none
module sor_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_mode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire sor_pkg::sor_sts_t sts,
  output sor_pkg::sor_cmd_t     cmd
);
  import sor_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.issue = 1'b1;
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (slot_free) begin
          cmd.deliver   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sts.last_pending ? ST_IDLE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (sts.pos_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/sor_datapath.sv */
// Datapath: matrix memory, configuration, load pointer, spiral cursor and output register.
`default_nettype none
module sor_datapath #(
  parameter int MAX_DIM    = sor_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = sor_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sor_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [sor_pkg::ELEM_W-1:0]    in_value,
  input  wire sor_pkg::sor_cmd_t             cmd,
  output sor_pkg::sor_sts_t                  sts,
  output logic [sor_pkg::ELEM_W-1:0]         out_element,
  output logic [sor_pkg::INDEX_W-1:0]        out_row_index,
  output logic [sor_pkg::INDEX_W-1:0]        out_col_index,
  output logic                               out_last
);
  import sor_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int TOT_W  = $clog2(DEPTH + 1);
  localparam int SW     = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;
  localparam int CW     = (DIM_W > CFG_W) ? DIM_W + 1 : CFG_W + 1;
  localparam int AW     = DIM_W + 2;
  localparam int MW     = IDX_W + DIM_W + 1;

  // Configuration
  logic [CFG_W-1:0] num_rows_r, num_cols_r;
  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic [TOT_W-1:0] total;

  // Load pointer and spiral cursor
  logic [TOT_W-1:0] lp_r, lp_nxt, lp_wr;
  logic [IDX_W-1:0] ring_r, ring_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [DIM_W-1:0] pos_r, pos_nxt;
  logic [TOT_W-1:0] emit_r, emit_nxt;

  // Position arithmetic
  logic [AW-1:0]     s, k, rows_a, cols_a, ex, ey, side_len, r_a, c_a, ring_up_a;
  logic              ring_ok;
  logic [IDX_W-1:0]  r_idx, c_idx, ring_up;
  logic [MW-1:0]     rd_addr_full;
  logic [ADDR_W-1:0] rd_addr;
  logic              is_last;

  // Memory and read pipeline
  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    rd_data_r;
  logic [IDX_W-1:0] row_q_r, col_q_r;
  logic             last_q_r;

  // Output register
  logic [ELEM_W-1:0]  out_elem_r;
  logic [INDEX_W-1:0] out_row_r, out_col_r;
  logic               out_last_r;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] vx;
    vx = CW'(v);
    if (vx == '0) begin
      return DIM_W'(1);
    end else if (vx > CW'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(vx);
  endfunction

  assign rows_eff = clamp_dim(num_rows_r);
  assign cols_eff = clamp_dim(num_cols_r);
  assign total    = TOT_W'(rows_eff * cols_eff);

  // Side lengths of the current ring
  assign s       = AW'(ring_r);
  assign k       = AW'(pos_r);
  assign rows_a  = AW'(rows_eff);
  assign cols_a  = AW'(cols_eff);
  assign ring_ok = (cols_a > (s << 1)) && (rows_a > (s << 1));
  assign ex      = cols_a - AW'(1) - s;
  assign ey      = rows_a - AW'(1) - s;

  always_comb begin
    side_len = '0;
    if (ring_ok) begin
      case (phase_r)
        SIDE_TOP:    side_len = ex - s + AW'(1);
        SIDE_RIGHT:  side_len = (s < ey) ? ey - s : '0;
        SIDE_BOTTOM: side_len = (s < ex && s < ey) ? ex - s : '0;
        default:     side_len = (s < ex && (s + AW'(1)) < ey) ? ey - s - AW'(1) : '0;
      endcase
    end
  end

  always_comb begin
    case (phase_r)
      SIDE_TOP: begin
        r_a = s;
        c_a = s + k;
      end
      SIDE_RIGHT: begin
        r_a = s + AW'(1) + k;
        c_a = ex;
      end
      SIDE_BOTTOM: begin
        r_a = ey;
        c_a = ex - AW'(1) - k;
      end
      default: begin
        r_a = ey - AW'(1) - k;
        c_a = s;
      end
    endcase
  end

  assign r_idx        = IDX_W'(r_a);
  assign c_idx        = IDX_W'(c_a);
  assign rd_addr_full = MW'(r_idx) * MW'(cols_eff) + MW'(c_idx);
  assign rd_addr      = ADDR_W'(rd_addr_full);
  assign is_last      = ((TOT_W + 1)'(emit_r) + (TOT_W + 1)'(1)) >= (TOT_W + 1)'(total);

  assign sts.pos_ok       = k < side_len;
  assign sts.last_pending = last_q_r;

  // Next ring after the left edge; wraps when the spiral is exhausted
  assign ring_up   = ring_r + IDX_W'(1);
  assign ring_up_a = AW'(ring_up);

  assign lp_wr = (lp_r >= total) ? '0 : lp_r;

  always_comb begin
    lp_nxt    = lp_r;
    ring_nxt  = ring_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    emit_nxt  = emit_r;
    if (cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
      lp_nxt    = '0;
      ring_nxt  = '0;
      phase_nxt = SIDE_TOP;
      pos_nxt   = '0;
      emit_nxt  = '0;
    end else if (cmd.load) begin
      if (lp_wr == '0) begin
        ring_nxt  = '0;
        phase_nxt = SIDE_TOP;
        pos_nxt   = '0;
        emit_nxt  = '0;
      end
      lp_nxt = ((TOT_W + 1)'(lp_wr) + (TOT_W + 1)'(1) >= (TOT_W + 1)'(total))
               ? '0 : lp_wr + TOT_W'(1);
    end else if (cmd.deliver) begin
      if (last_q_r) begin
        ring_nxt  = '0;
        phase_nxt = SIDE_TOP;
        pos_nxt   = '0;
        emit_nxt  = '0;
      end else begin
        emit_nxt = emit_r + TOT_W'(1);
        pos_nxt  = pos_r + DIM_W'(1);
      end
    end else if (cmd.step) begin
      pos_nxt   = '0;
      phase_nxt = phase_r + 2'd1;
      if (phase_r == SIDE_LEFT) begin
        if (cols_a <= (ring_up_a << 1) || rows_a <= (ring_up_a << 1)) begin
          ring_nxt = '0;
        end else begin
          ring_nxt = ring_up;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_RESET;
      num_cols_r <= DIM_RESET;
      lp_r       <= '0;
      ring_r     <= '0;
      phase_r    <= SIDE_TOP;
      pos_r      <= '0;
      emit_r     <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_NUM_COLS) begin
        num_cols_r <= cfg_data;
      end
      lp_r    <= lp_nxt;
      ring_r  <= ring_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Matrix memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[ADDR_W'(lp_wr)] <= in_value[SW-1:0];
    end
    if (cmd.issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Position latch, with last flag control-like so it resets
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      row_q_r <= r_idx;
      col_q_r <= c_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_q_r <= 1'b0;
    end else if (cmd.issue) begin
      last_q_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_elem_r <= ELEM_W'($signed(rd_data_r));
      out_row_r  <= INDEX_W'(row_q_r);
      out_col_r  <= INDEX_W'(col_q_r);
      out_last_r <= last_q_r;
    end
  end

  assign out_element   = out_elem_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the spiral-order matrix reader.
`default_nettype none
module tb_top;
  import sor_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int STORE_DEPTH    = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int RANDOM_ITEMS   = 1250;
  // Receiver hold-off used to back the block up into its input channel
  localparam int HOLD_CYCLES    = 160;
  // Slack given before a register write, once every owed result is in.
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  // Worst case per item is roughly a long sender gap, a long receiver gap
  // and the slowest spiral transfer; several times that over the whole run.
  localparam int TIMEOUT_CYCLES = 1_200_000;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] col_index;
    logic               last;
  } spiral_result_t;

  // Predicts the spiral walk and holds the results still owed by the block.
  class spiral_scoreboard;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    logic [ELEM_W-1:0] store [STORE_DEPTH];
    bit                loaded [STORE_DEPTH];
    int unsigned       load_ptr;
    int unsigned       ring;
    logic [1:0]        side;
    int unsigned       pos;
    int unsigned       emitted;
    spiral_result_t    expected_q[$];
    int unsigned       errors;

    function new();
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      load_ptr = 0;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      ring    = 0;
      side    = SIDE_TOP;
      pos     = 0;
      emitted = 0;
    endfunction

    // 0 reads as 1, anything past the array size as the array size
    function int unsigned clamp(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function int unsigned rows();
      return clamp(rows_reg);
    endfunction

    function int unsigned cols();
      return clamp(cols_reg);
    endfunction

    function int unsigned cells();
      return rows() * cols();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Length of side p of ring s; 0 where that side is skipped
    function int unsigned side_len(int unsigned s, logic [1:0] p);
      int unsigned nr;
      int unsigned nc;
      int unsigned ex;
      int unsigned ey;
      nr = rows();
      nc = cols();
      if (nc <= 2 * s || nr <= 2 * s) return 0;
      ex = nc - 1 - s;
      ey = nr - 1 - s;
      case (p)
        SIDE_TOP:    return ex - s + 1;
        SIDE_RIGHT:  return (s < ey) ? ey - s : 0;
        SIDE_BOTTOM: return (s < ex && s < ey) ? ex - s : 0;
        default:     return (s < ex && s + 1 < ey) ? ey - s - 1 : 0;
      endcase
    endfunction

    // Step the cursor on until it sits on a walked position
    function void settle(inout int unsigned s, inout logic [1:0] p, inout int unsigned k);
      int unsigned guard;
      guard = 0;
      while (k >= side_len(s, p)) begin
        k = 0;
        p = p + 2'd1;
        if (p == SIDE_TOP) begin
          s++;
          if (cols() <= 2 * s || rows() <= 2 * s) s = 0;
        end
        guard++;
        if (guard > 4 * (MAX_DIM_DEF + 2)) begin
          s = 0;
          p = SIDE_TOP;
          k = 0;
          break;
        end
      end
    endfunction

    function void locate(int unsigned s, logic [1:0] p, int unsigned k,
                         output int unsigned r, output int unsigned c);
      int unsigned ex;
      int unsigned ey;
      ex = cols() - 1 - s;
      ey = rows() - 1 - s;
      case (p)
        SIDE_TOP:    begin r = s;          c = s + k;      end
        SIDE_RIGHT:  begin r = s + 1 + k;  c = ex;         end
        SIDE_BOTTOM: begin r = ey;         c = ex - 1 - k; end
        default:     begin r = ey - 1 - k; c = s;          end
      endcase
    endfunction

    // True when the next spiral request would read a slot already loaded
    function bit emit_reads_loaded();
      int unsigned s;
      int unsigned k;
      int unsigned r;
      int unsigned c;
      logic [1:0]  p;
      s = ring;
      p = side;
      k = pos;
      if (emitted >= cells()) begin
        s = 0;
        p = SIDE_TOP;
        k = 0;
      end
      settle(s, p, k);
      locate(s, p, k, r, c);
      return loaded[(r * cols() + c) % STORE_DEPTH];
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_NUM_ROWS) rows_reg = data;
      else cols_reg = data;
      load_ptr = 0;
      restart();
    endfunction

    function void note_transfer(logic mode, logic [ELEM_W-1:0] value);
      int unsigned    r;
      int unsigned    c;
      spiral_result_t res;
      if (mode == MODE_LOAD) begin
        if (load_ptr >= cells()) load_ptr = 0;
        if (load_ptr == 0) restart();
        store[load_ptr]  = value;
        loaded[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= cells()) load_ptr = 0;
        return;
      end
      if (emitted >= cells()) restart();
      settle(ring, side, pos);
      locate(ring, side, pos, r, c);
      res.element   = store[(r * cols() + c) % STORE_DEPTH];
      res.row_index = r[INDEX_W-1:0];
      res.col_index = c[INDEX_W-1:0];
      res.last      = (emitted + 1 >= cells());
      expected_q.push_back(res);
      if (res.last) begin
        restart();
      end else begin
        emitted++;
        pos++;
        settle(ring, side, pos);
      end
    endfunction

    function void compare_field(string name, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(spiral_result_t got);
      spiral_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: element %h row %0d col %0d last %0b",
                 $time, got.element, got.row_index, got.col_index, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("element", want.element, got.element);
      compare_field("row_index", ELEM_W'(want.row_index), ELEM_W'(got.row_index));
      compare_field("col_index", ELEM_W'(want.col_index), ELEM_W'(got.col_index));
      compare_field("last", ELEM_W'(want.last), ELEM_W'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sor_in_if  in_if ();
  sor_out_if out_if ();

  spiral_scoreboard sb = new();

  // quiet: no idling on either side for the current phase
  bit quiet;
  // set by the stimulus to ask the receiver for one long hold-off
  bit hold_request;

  spiral_order_matrix_reader u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int draw;
    if (quiet) return 0;
    draw = $urandom_range(0, 99);
    if (draw < 55) return 0;
    if (draw < 85) return $urandom_range(1, 3);
    if (draw < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one item, wait for the transfer, then maybe idle a while.
  // Prediction happens here, at the accepting edge, so the next item's
  // choice always sees up-to-date state.
  task automatic offer(input logic mode, input logic [ELEM_W-1:0] value);
    int gap;
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.value <= value;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_transfer(mode, value);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Spiral request where it only touches loaded slots, otherwise a load
  task automatic offer_checked(input bit want_emit);
    if (want_emit && sb.emit_reads_loaded()) offer(MODE_EMIT, $urandom);
    else offer(MODE_LOAD, $urandom);
  endtask

  // Drain every owed result, then let any trailing load retire
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.apply_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check every transfer, pick the next stall, and honour
  // the long hold-off when asked (counted here, not in the sender).
  initial begin : result_sink
    int             gap_left;
    int             hold_left;
    spiral_result_t got;
    gap_left  = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.element   = out_if.element;
        got.row_index = out_if.row_index;
        got.col_index = out_if.col_index;
        got.last      = out_if.last;
        sb.check_result(got);
        gap_left = pick_gap();
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [ELEM_W-1:0] corner_vals [6];
    logic [CFG_W-1:0]  nr;
    logic [CFG_W-1:0]  nc;
    int                random_items;
    int                phase_no;
    int                total;
    int                n_emit;
    int                choice;
    bit                well_formed;
    bit                pressure_done;

    corner_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                    32'hffff_ffff, 32'h0000_0001, 32'h5555_5555};
    random_items  = 0;
    phase_no      = 0;
    pressure_done = 1'b0;
    quiet         = 1'b0;
    hold_request  = 1'b0;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_NUM_ROWS;
    cfg_data    <= '0;
    in_if.valid <= 1'b0;
    in_if.mode  <= MODE_LOAD;
    in_if.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2x3 matrix with the value extremes, a walk past the last
    // element back to the start, then a reload of slot zero mid-spiral
    // (load pointer has wrapped) which must restart the walk.
    write_reg(REG_NUM_ROWS, 6'd2);
    write_reg(REG_NUM_COLS, 6'd3);
    foreach (corner_vals[i]) offer(MODE_LOAD, corner_vals[i]);
    repeat (7) offer(MODE_EMIT, $urandom);
    offer(MODE_LOAD, 32'haaaa_aaaa);
    repeat (2) offer(MODE_EMIT, $urandom);

    // Zero-sized dimensions read as 1x1
    wait_idle();
    write_reg(REG_NUM_ROWS, 6'd0);
    write_reg(REG_NUM_COLS, 6'd0);
    offer(MODE_LOAD, $urandom);
    repeat (2) offer(MODE_EMIT, $urandom);

    // Random phases, each starting from an idle block
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      phase_no++;

      choice = $urandom_range(0, 99);
      if (choice < 65) begin
        nr = CFG_W'($urandom_range(1, 6));
        nc = CFG_W'($urandom_range(1, 6));
      end else if (choice < 80) begin
        case ($urandom_range(0, 3))
          0:       begin nr = 6'd32; nc = 6'd1;  end
          1:       begin nr = 6'd1;  nc = 6'd32; end
          2:       begin nr = 6'd32; nc = 6'd2;  end
          default: begin nr = 6'd2;  nc = 6'd32; end
        endcase
      end else if (choice < 90) begin
        // out-of-range register values on one axis
        nr = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'd63;
        nc = CFG_W'($urandom_range(1, 5));
        if ($urandom_range(0, 1) != 0) {nr, nc} = {nc, nr};
      end else begin
        nr = CFG_W'($urandom_range(1, 12));
        nc = CFG_W'($urandom_range(1, 12));
      end

      // Either order, or one register only (the other keeps its value)
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          write_reg(REG_NUM_ROWS, nr);
          write_reg(REG_NUM_COLS, nc);
        end
        3: begin
          write_reg(REG_NUM_COLS, nc);
          write_reg(REG_NUM_ROWS, nr);
        end
        4:       write_reg(REG_NUM_ROWS, nr);
        default: write_reg(REG_NUM_COLS, nc);
      endcase

      quiet       = ($urandom_range(0, 4) == 0);
      well_formed = ($urandom_range(0, 9) < 8);
      total       = sb.cells();

      if (well_formed) begin
        // Fill the matrix, then walk past its end at least once; the odd
        // stray load overwrites a slot or, once the pointer has wrapped,
        // restarts the walk.
        repeat (total) offer(MODE_LOAD, $urandom);
        n_emit = total + $urandom_range(1, total);
        if (!pressure_done && phase_no >= 2) begin
          pressure_done = 1'b1;
          quiet         = 1'b1;
          n_emit        = n_emit + 20;
          hold_request  = 1'b1;
        end
        repeat (n_emit) offer_checked($urandom_range(0, 19) != 0);
        random_items = random_items + total + n_emit;
      end else begin
        // Loose mix of loads and requests over whatever is stored
        n_emit = $urandom_range(5, 40);
        repeat (n_emit) offer_checked($urandom_range(0, 1) != 0);
        random_items = random_items + n_emit;
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
